FILE: rtl/bds_pkg.sv
// bds_pkg: shared types and constants of the 2x2 box downsampler
// used by bds_cfg, bds_scan, bds_store and box_downsample_2x2
package bds_pkg;

	localparam int unsigned WIDTH_REG_W   = 13;
	localparam int unsigned HEIGHT_REG_W  = 16;
	localparam int unsigned CHAN_REG_W    = 3;
	localparam int unsigned EFF_W_W       = 17;
	localparam int unsigned CH_W          = 2;
	localparam int unsigned HOLD_DEPTH    = 4;
	localparam int unsigned SAMPLE_W      = 8;
	localparam int unsigned PAIR_W        = 9;
	localparam int unsigned SUM_W         = 10;
	localparam int unsigned ADDR_W        = 4;
	localparam int unsigned DATA_W        = 32;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = 13'd2;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = 16'd2;
	localparam logic [CHAN_REG_W-1:0]   CHANNELS_RESET = 3'd4;

	typedef struct packed {
		logic [EFF_W_W-1:0]      eff_w;
		logic [HEIGHT_REG_W-1:0] eff_h;
		logic [CHAN_REG_W-1:0]   eff_c;
	} cfg_t;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic              last;
		logic [PAIR_W-1:0] pair;
	} scan_t;

endpackage

FILE: rtl/bds_cfg.sv
// bds_cfg: register port and clamped image geometry
// depends on bds_pkg
module bds_cfg #(
	parameter int unsigned MAX_WIDTH    = 4096,
	parameter int unsigned MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bds_pkg::ADDR_W-1:0]    paddr,
	input  logic [bds_pkg::DATA_W-1:0]    pwdata,
	output logic [bds_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output bds_pkg::cfg_t                 cfg
);

	logic [bds_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [bds_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [bds_pkg::CHAN_REG_W-1:0]   chan_q;
	logic [1:0]                       reg_idx;
	logic                             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bds_pkg::WIDTH_RESET;
			height_q <= bds_pkg::HEIGHT_RESET;
			chan_q   <= bds_pkg::CHANNELS_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				bds_pkg::REG_WIDTH:    width_q  <= pwdata[bds_pkg::WIDTH_REG_W-1:0];
				bds_pkg::REG_HEIGHT:   height_q <= pwdata[bds_pkg::HEIGHT_REG_W-1:0];
				bds_pkg::REG_CHANNELS: chan_q   <= pwdata[bds_pkg::CHAN_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bds_pkg::REG_WIDTH:    prdata = bds_pkg::DATA_W'(width_q);
			bds_pkg::REG_HEIGHT:   prdata = bds_pkg::DATA_W'(height_q);
			bds_pkg::REG_CHANNELS: prdata = bds_pkg::DATA_W'(chan_q);
			default:               prdata = '0;
		endcase
	end

	// clamp out-of-range geometry
	always_comb begin
		if (width_q == '0)
			cfg.eff_w = bds_pkg::EFF_W_W'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			cfg.eff_w = bds_pkg::EFF_W_W'(MAX_WIDTH);
		else
			cfg.eff_w = bds_pkg::EFF_W_W'(width_q);
		cfg.eff_h = (height_q == '0) ? bds_pkg::HEIGHT_REG_W'(1) : height_q;
		if (chan_q == '0)
			cfg.eff_c = bds_pkg::CHAN_REG_W'(1);
		else if (32'(chan_q) > 32'(MAX_CHANNELS))
			cfg.eff_c = bds_pkg::CHAN_REG_W'(MAX_CHANNELS);
		else
			cfg.eff_c = chan_q;
	end

endmodule

FILE: rtl/bds_scan.sv
// bds_scan: raster position counters, left sample hold, pair sum and row store address
// depends on bds_pkg
module bds_scan #(
	parameter int unsigned COL_W     = 12,
	parameter int unsigned AW        = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [bds_pkg::SAMPLE_W-1:0]    sample,
	input  bds_pkg::cfg_t                   cfg,
	output bds_pkg::scan_t                  scan,
	output logic [AW-1:0]                   addr
);

	logic [COL_W-1:0]                 col_q;
	logic [bds_pkg::CH_W-1:0]         ch_q;
	logic [bds_pkg::HEIGHT_REG_W-1:0] row_q;
	logic [bds_pkg::SAMPLE_W-1:0]     hold_q [bds_pkg::HOLD_DEPTH];

	logic                             active;
	logic [bds_pkg::EFF_W_W-1:0]      col_ext;
	logic [bds_pkg::CHAN_REG_W-1:0]   ch_ext;
	logic [bds_pkg::CHAN_REG_W-1:0]   ch_nx;
	logic [COL_W:0]                   col_nx;
	logic [bds_pkg::HEIGHT_REG_W:0]   row_nx;
	logic [bds_pkg::EFF_W_W-1:0]      w_last;
	logic [bds_pkg::HEIGHT_REG_W:0]   h_last;
	logic [AW-1:0]                    half;

	assign col_ext = bds_pkg::EFF_W_W'(col_q);
	assign ch_ext  = bds_pkg::CHAN_REG_W'(ch_q);
	assign active  = (col_ext < cfg.eff_w) && (ch_ext < cfg.eff_c) && (row_q < cfg.eff_h);

	assign scan.pair = bds_pkg::PAIR_W'(hold_q[ch_q]) + bds_pkg::PAIR_W'(sample);
	assign scan.wr   = active & col_q[0] & ~row_q[0];
	assign scan.rd   = active & col_q[0] & row_q[0];

	// last column and row of the even-cropped image
	assign w_last = {cfg.eff_w[bds_pkg::EFF_W_W-1:1], 1'b0} - bds_pkg::EFF_W_W'(1);
	assign h_last = {1'b0, cfg.eff_h[bds_pkg::HEIGHT_REG_W-1:1], 1'b0}
		- (bds_pkg::HEIGHT_REG_W+1)'(1);
	assign scan.last = ({1'b0, row_q} == h_last) && (col_ext == w_last)
		&& (ch_ext == cfg.eff_c - bds_pkg::CHAN_REG_W'(1));

	assign half = AW'(col_q >> 1);

	always_comb begin
		unique case (cfg.eff_c)
			3'd2:    addr = (half << 1) + AW'(ch_q);
			3'd3:    addr = (half << 1) + half + AW'(ch_q);
			3'd4:    addr = (half << 2) + AW'(ch_q);
			default: addr = half + AW'(ch_q);
		endcase
	end

	assign ch_nx  = ch_ext + bds_pkg::CHAN_REG_W'(1);
	assign col_nx = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_nx = {1'b0, row_q} + (bds_pkg::HEIGHT_REG_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			ch_q  <= '0;
			row_q <= '0;
			for (int i = 0; i < bds_pkg::HOLD_DEPTH; i++)
				hold_q[i] <= '0;
		end else if (accept) begin
			if (active && !col_q[0])
				hold_q[ch_q] <= sample;
			if (ch_nx >= cfg.eff_c) begin
				ch_q <= '0;
				if (bds_pkg::EFF_W_W'(col_nx) >= cfg.eff_w) begin
					col_q <= '0;
					if (row_nx >= {1'b0, cfg.eff_h})
						row_q <= '0;
					else
						row_q <= row_nx[bds_pkg::HEIGHT_REG_W-1:0];
				end else begin
					col_q <= col_nx[COL_W-1:0];
				end
			end else begin
				ch_q <= ch_nx[bds_pkg::CH_W-1:0];
			end
		end
	end

endmodule

FILE: rtl/bds_store.sv
// bds_store: row store of horizontal pair sums, one write or one registered read per cycle
// depends on bds_pkg
module bds_store #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic                          clk,
	input  logic                          wr,
	input  logic                          rd,
	input  logic [AW-1:0]                 addr,
	input  logic [bds_pkg::PAIR_W-1:0]    wdata,
	output logic [bds_pkg::PAIR_W-1:0]    rdata
);

	logic [bds_pkg::PAIR_W-1:0] mem [DEPTH];
	logic [bds_pkg::PAIR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr)
			mem[addr] <= wdata;
		if (rd)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/box_downsample_2x2.sv
// box_downsample_2x2: 2x2 box filter mipmap reduction of an interleaved 8-bit sample stream
// a sample that completes a word passes the read stage, then the output register, before the word reaches the output
// throughput: one sample per clock while the input is not stalled; the row store takes at most one access per sample
// input stalls only while the read stage and the output register both hold a word and result_stall is high
// reset clears counters, left holds and pipeline valids; registers go to 2 x 2, 4 channels
// the row store is not cleared; every entry is written on an even row before it is read
module box_downsample_2x2 #(
	parameter int unsigned MAX_WIDTH    = 4096,
	parameter int unsigned MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bds_pkg::ADDR_W-1:0]    paddr,
	input  logic [bds_pkg::DATA_W-1:0]    pwdata,
	output logic [bds_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [bds_pkg::SAMPLE_W-1:0]  sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bds_pkg::SAMPLE_W-1:0]  average,
	output logic                          image_end
);

	localparam int unsigned DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

	bds_pkg::cfg_t                cfg;
	bds_pkg::scan_t               scan;
	logic [AW-1:0]                addr;
	logic [bds_pkg::PAIR_W-1:0]   rdata;
	logic                         accept;
	logic                         s2_go;
	logic                         v_s1;
	logic [bds_pkg::PAIR_W-1:0]   pair_s1;
	logic                         last_s1;
	logic [bds_pkg::SUM_W-1:0]    sum;
	logic                         out_valid_q;
	logic [bds_pkg::SAMPLE_W-1:0] average_q;
	logic                         image_end_q;

	bds_cfg #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bds_scan #(
		.COL_W     (COL_W),
		.AW        (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.cfg    (cfg),
		.scan   (scan),
		.addr   (addr)
	);

	bds_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.wr    (accept & scan.wr),
		.rd    (accept & scan.rd),
		.addr  (addr),
		.wdata (scan.pair),
		.rdata (rdata)
	);

	assign s2_go        = ~out_valid_q | ~result_stall;
	assign sample_stall = v_s1 & ~s2_go;
	assign accept       = sample_valid & ~sample_stall;
	assign sum          = bds_pkg::SUM_W'(rdata) + bds_pkg::SUM_W'(pair_s1);

	// read stage: store data arrives alongside the pair sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= scan.rd;
		end else if (s2_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1 <= scan.pair;
			last_s1 <= scan.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s2_go)
			out_valid_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_go && v_s1) begin
			average_q   <= sum[bds_pkg::SUM_W-1:2];
			image_end_q <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign average      = average_q;
	assign image_end    = image_end_q;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v_s1 && out_valid_q && result_stall)
		else $error("input stalled without a blocked word");
	a_read_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan.rd |=> v_s1)
		else $error("store read lost at read stage");
	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && s2_go |=> out_valid_q)
		else $error("word dropped between read stage and output");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan.wr |=> !v_s1)
		else $error("store write produced a word");
`endif

endmodule
